// File: src/npt_pkg.sv
// ----------------------------------------------------------------------------
// npt_pkg
// shared types and codes for the nearest point table
// ----------------------------------------------------------------------------
package npt_pkg;

   localparam int unsigned POINT_BITS       = 12;
   localparam int unsigned ENTRY_INDEX_BITS = 10;
   localparam int unsigned STATUS_BITS      = 2;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_QUERY  = 1'b1;

   localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic                  mode;
      logic [POINT_BITS-1:0] point_x;
      logic [POINT_BITS-1:0] point_y;
   } npt_req_type;

   typedef struct packed {
      logic [ENTRY_INDEX_BITS-1:0] entry_index;
      logic [STATUS_BITS-1:0]      status;
   } npt_rsp_type;

   typedef enum logic [1:0] {
      RSP_INSERT,
      RSP_FULL,
      RSP_EMPTY,
      RSP_QUERY
   } npt_rsp_kind_type;

   typedef struct packed {
      logic             load_req;
      logic             write_point;
      logic             scan_init;
      logic             scan_issue;
      logic             respond;
      npt_rsp_kind_type rsp_kind;
   } npt_cmd_type;

   typedef struct packed {
      logic mode_query;
      logic full;
      logic empty;
      logic last_addr;
      logic pipe_busy;
   } npt_stat_type;

endpackage

// File: src/npt_ctrl.sv
// ----------------------------------------------------------------------------
// npt_ctrl
// sequencer for insert and scan operations of the nearest point table
// ----------------------------------------------------------------------------
module npt_ctrl
   import npt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   output logic         rsp_strobe,
   output npt_cmd_type  cmd,
   input  npt_stat_type stat
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_DRAIN
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;
   logic      strobe_ff, strobe_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.rsp_kind = RSP_INSERT;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               state_in     = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!stat.mode_query) begin
               cmd.respond = 1'b1;
               state_in    = ST_IDLE;
               if (stat.full) begin
                  cmd.rsp_kind = RSP_FULL;
               end else begin
                  cmd.rsp_kind    = RSP_INSERT;
                  cmd.write_point = 1'b1;
               end
            end else if (stat.empty) begin
               cmd.respond  = 1'b1;
               cmd.rsp_kind = RSP_EMPTY;
               state_in     = ST_IDLE;
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (stat.last_addr) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!stat.pipe_busy) begin
               cmd.respond  = 1'b1;
               cmd.rsp_kind = RSP_QUERY;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      busy_in   = (state_in != ST_IDLE);
      strobe_in = cmd.respond;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         busy_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         busy_ff   <= busy_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;

endmodule

// File: src/npt_datapath.sv
// ----------------------------------------------------------------------------
// npt_datapath
// point memory, fill count, squared distance pipeline and best tracker
// ----------------------------------------------------------------------------
module npt_datapath
   import npt_pkg::*;
#(
   parameter int unsigned CAPACITY   = 1024,
   parameter int unsigned COORD_BITS = 12
) (
   input  logic         clock,
   input  logic         reset,
   input  npt_req_type  req_data,
   input  npt_cmd_type  cmd,
   output npt_stat_type stat,
   output npt_rsp_type  rsp_data
);

   localparam int unsigned AW   = $clog2(CAPACITY);
   localparam int unsigned CNTW = $clog2(CAPACITY + 1);
   localparam int unsigned CW   = COORD_BITS;
   localparam int unsigned SQW  = 2 * CW;
   localparam int unsigned DW   = 2 * CW + 1;

   logic [2*CW-1:0] mem [CAPACITY];

   logic            mode_ff;
   logic [CW-1:0]   qx_ff, qy_ff;
   logic [CNTW-1:0] count_ff, count_in;
   logic [AW-1:0]   addr_ff, addr_in;
   logic [2*CW-1:0] rd_ff;
   logic [AW-1:0]   idx1_ff, idx2_ff;
   logic            v1_ff, v2_ff;
   logic [SQW-1:0]  sqx_ff, sqy_ff, sqx_in, sqy_in;
   logic [DW-1:0]   best_ff, best_in, cand_dist;
   logic [AW-1:0]   best_idx_ff, best_idx_in;
   logic            best_valid_ff, best_valid_in;
   npt_rsp_type     rsp_ff, rsp_in;
   logic [CW-1:0]   rx, ry, dx, dy;

   // distance stage inputs
   always_comb begin
      rx     = rd_ff[CW-1:0];
      ry     = rd_ff[2*CW-1:CW];
      dx     = (rx >= qx_ff) ? (rx - qx_ff) : (qx_ff - rx);
      dy     = (ry >= qy_ff) ? (ry - qy_ff) : (qy_ff - ry);
      sqx_in = SQW'(dx) * SQW'(dx);
      sqy_in = SQW'(dy) * SQW'(dy);
   end

   // compare stage
   always_comb begin
      cand_dist     = DW'(sqx_ff) + DW'(sqy_ff);
      best_in       = best_ff;
      best_idx_in   = best_idx_ff;
      best_valid_in = best_valid_ff;
      if (cmd.scan_init) begin
         best_valid_in = 1'b0;
      end else if (v2_ff && (!best_valid_ff || cand_dist < best_ff)) begin
         best_in       = cand_dist;
         best_idx_in   = idx2_ff;
         best_valid_in = 1'b1;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.write_point) begin
         count_in = count_ff + CNTW'(1);
      end
      addr_in = addr_ff;
      if (cmd.scan_init) begin
         addr_in = '0;
      end else if (cmd.scan_issue) begin
         addr_in = addr_ff + AW'(1);
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      unique case (cmd.rsp_kind)
         RSP_INSERT: begin
            rsp_in.entry_index = ENTRY_INDEX_BITS'(count_ff);
            rsp_in.status      = STATUS_OK;
         end
         RSP_FULL: begin
            rsp_in.entry_index = '0;
            rsp_in.status      = STATUS_FULL;
         end
         RSP_EMPTY: begin
            rsp_in.entry_index = '0;
            rsp_in.status      = STATUS_EMPTY;
         end
         RSP_QUERY: begin
            rsp_in.entry_index = ENTRY_INDEX_BITS'(best_idx_ff);
            rsp_in.status      = STATUS_OK;
         end
         default: begin
            rsp_in = rsp_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.write_point) begin
         mem[count_ff[AW-1:0]] <= {qy_ff, qx_ff};
      end
      if (cmd.scan_issue) begin
         rd_ff <= mem[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         best_valid_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         v1_ff         <= cmd.scan_issue;
         v2_ff         <= v1_ff;
         best_valid_ff <= best_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         mode_ff <= req_data.mode;
         qx_ff   <= CW'(req_data.point_x);
         qy_ff   <= CW'(req_data.point_y);
      end
      if (cmd.respond) begin
         rsp_ff <= rsp_in;
      end
      addr_ff     <= addr_in;
      idx1_ff     <= addr_ff;
      idx2_ff     <= idx1_ff;
      sqx_ff      <= sqx_in;
      sqy_ff      <= sqy_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
   end

   assign stat.mode_query = (mode_ff == MODE_QUERY);
   assign stat.full       = (count_ff == CNTW'(CAPACITY));
   assign stat.empty      = (count_ff == '0);
   assign stat.last_addr  = ((CNTW'(addr_ff) + CNTW'(1)) == count_ff);
   assign stat.pipe_busy  = v1_ff | v2_ff;
   assign rsp_data        = rsp_ff;

endmodule

// File: src/nearest_point_table.sv
// ----------------------------------------------------------------------------
// nearest_point_table
// table of 2-d points with linear nearest point search by squared distance
// ----------------------------------------------------------------------------
// insert: strobe is registered from the check state, and the next word is
//   taken at the edge that ends the strobe cycle
// query: the scan reads every stored point through the one memory read port
//   and distance unit, drains the pipeline, then raises the registered strobe
// one word in flight; busy stays high until the result strobe cycle
// synchronous reset empties the table; point memory is not cleared
module nearest_point_table
   import npt_pkg::*;
#(
   parameter int unsigned CAPACITY   = 1024,
   parameter int unsigned COORD_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  npt_req_type req_data,
   output logic        rsp_strobe,
   output npt_rsp_type rsp_data
);

   npt_cmd_type  cmd;
   npt_stat_type stat;

   npt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .stat       (stat)
   );

   npt_datapath #(
      .CAPACITY   (CAPACITY),
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule
